// ===== rtl/ddw_pkg.sv =====
// shared types and constants of the differential-drive wheel pi controller
`default_nettype none

package ddw_pkg;

   // operand and product widths of the shared multiply/divide unit
   localparam int OPA_W = 50;
   localparam int OPB_W = 60;
   localparam int PROD_W = OPA_W + OPB_W;
   localparam int DIVIDEND_W = 43;
   localparam int DIVISOR_W = 24;
   localparam int CNT_W = 6;
   localparam int INTEG_W = 48;

   localparam logic [2:0] CSR_PROP_GAIN = 3'd0;
   localparam logic [2:0] CSR_INTEG_GAIN = 3'd1;
   localparam logic [2:0] CSR_DRIVE_HIGH = 3'd2;
   localparam logic [2:0] CSR_DRIVE_LOW = 3'd3;
   localparam logic [2:0] CSR_WHEEL_SPACING = 3'd4;

   localparam logic [23:0] PROP_GAIN_RST = 24'd51200;
   localparam logic [23:0] INTEG_GAIN_RST = 24'd12800;
   localparam logic [15:0] DRIVE_HIGH_RST = 16'd25600;
   localparam logic [15:0] DRIVE_LOW_RST = 16'd11520;
   localparam logic [15:0] WHEEL_SPACING_RST = 16'd38;

   typedef enum logic [1:0] {
      DIR_FWD = 2'd0,
      DIR_BACK = 2'd1,
      DIR_BRAKE = 2'd2
   } dir_type;

   typedef enum logic {
      MDU_MUL,
      MDU_DIV
   } mdu_op_type;

   typedef struct packed {
      logic start;
      mdu_op_type op;
   } mdu_req_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_LAUNCH,
      ST_WAIT,
      ST_POST,
      ST_ERR,
      ST_MIX,
      ST_CLAMP,
      ST_UPD,
      ST_FIN
   } state_type;

   typedef enum logic [2:0] {
      OP_TURN,
      OP_RATE,
      OP_DTKI,
      OP_DTRATE,
      OP_PROP,
      OP_T1,
      OP_T2
   } step_type;

endpackage

`default_nettype wire

// ===== rtl/ddw_mul_div.sv =====
// shared shift-add multiplier and restoring divider, one bit per cycle
`default_nettype none

module ddw_mul_div import ddw_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  mdu_req_type       mdu_req,
   input  logic [OPA_W-1:0]  opa,
   input  logic [OPB_W-1:0]  opb,
   output logic              mdu_done,
   output logic [PROD_W-1:0] mdu_result
);

   logic                  active_ff;
   logic                  done_ff;
   mdu_op_type            op_ff;
   logic [PROD_W-1:0]     acc_ff;
   logic [PROD_W-1:0]     mcand_ff;
   logic [OPB_W-1:0]      mplr_ff;
   logic [DIVISOR_W-1:0]  rem_ff;
   logic [DIVISOR_W-1:0]  dvs_ff;
   logic [DIVIDEND_W-1:0] nq_ff;
   logic [CNT_W-1:0]      cnt_ff;

   logic [DIVISOR_W:0]    shifted;
   logic                  fits;
   logic [DIVISOR_W-1:0]  rem_in;

   always_comb begin
      shifted = {rem_ff, nq_ff[DIVIDEND_W-1]};
      fits = shifted >= {1'b0, dvs_ff};
      if (fits) begin
         rem_in = DIVISOR_W'(shifted - {1'b0, dvs_ff});
      end else begin
         rem_in = shifted[DIVISOR_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         if (mdu_req.start) begin
            active_ff <= 1'b1;
         end else if (active_ff) begin
            if (op_ff == MDU_MUL) begin
               if (mplr_ff == '0) begin
                  active_ff <= 1'b0;
                  done_ff <= 1'b1;
               end
            end else if (cnt_ff == CNT_W'(1)) begin
               active_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (mdu_req.start) begin
         op_ff <= mdu_req.op;
         acc_ff <= '0;
         mcand_ff <= {{(PROD_W-OPA_W){1'b0}}, opa};
         mplr_ff <= opb;
         rem_ff <= '0;
         dvs_ff <= opb[DIVISOR_W-1:0];
         nq_ff <= opa[DIVIDEND_W-1:0];
         cnt_ff <= CNT_W'(DIVIDEND_W);
      end else if (active_ff) begin
         if (op_ff == MDU_MUL) begin
            if (mplr_ff[0]) begin
               acc_ff <= acc_ff + mcand_ff;
            end
            mcand_ff <= {mcand_ff[PROD_W-2:0], 1'b0};
            mplr_ff <= {1'b0, mplr_ff[OPB_W-1:1]};
         end else begin
            rem_ff <= rem_in;
            nq_ff <= {nq_ff[DIVIDEND_W-2:0], fits};
            cnt_ff <= cnt_ff - CNT_W'(1);
         end
      end
   end

   assign mdu_done = done_ff;
   assign mdu_result = (op_ff == MDU_DIV) ? {{(PROD_W-DIVIDEND_W){1'b0}}, nq_ff} : acc_ff;

endmodule

`default_nettype wire

// ===== rtl/diff_drive_wheel_pi_controller.sv =====
// Differential-drive wheel PI controller with back-calculation anti-windup.
// Each request on the req_ channel is one control tick: linear and angular
// command, both measured wheel speeds and the time step. The block returns
// one response on the rsp_ channel with direction and clamped drive per wheel.
// Gains, drive limits and wheel spacing are written through the csr_ port;
// the user must write them only while the block is idle; the block does not enforce it.
// All arithmetic runs through one shared shift-add multiplier / restoring
// divider that retires one bit per cycle; a multiply step ends once its
// multiplier operand's significant bits are used up, and the back-calculation
// rate division runs over all dividend bits, so a tick's length is set by
// those operand widths. One tick is in flight at a time and req_stall is high
// until the result sits in the output register.
// The output register is separate, so a new request is taken while a response
// waits on rsp_stall; a finished tick waits only if the previous response has
// not been taken yet.
// Synchronous reset restores the register defaults, zeroes both integrators
// and empties the output register.
`default_nettype none

module diff_drive_wheel_pi_controller import ddw_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [15:0] req_linear_cmd,
   input  logic [15:0] req_angular_cmd,
   input  logic [15:0] req_left_speed,
   input  logic [15:0] req_right_speed,
   input  logic [15:0] req_step_time,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [1:0]  rsp_left_dir,
   output logic [1:0]  rsp_right_dir,
   output logic [15:0] rsp_left_drive,
   output logic [15:0] rsp_right_drive,
   input  logic        csr_we,
   input  logic [2:0]  csr_index,
   input  logic [23:0] csr_wdata
);

   function automatic logic signed [INTEG_W-1:0] mul_sat(input logic [PROD_W-1:0] prod,
                                                       input logic neg,
                                                       input logic [5:0] sh);
      logic [PROD_W-1:0] q;
      logic [PROD_W-1:0] mask;
      logic              rnd;
      logic [PROD_W-1:0] qq;
      q = prod >> sh;
      mask = (PROD_W'(1) << sh) - PROD_W'(1);
      rnd = neg && ((prod & mask) != '0);
      qq = q + PROD_W'(rnd);
      if (neg) begin
         if (qq > (PROD_W'(1) << (INTEG_W-1))) begin
            mul_sat = {1'b1, {(INTEG_W-1){1'b0}}};
         end else begin
            mul_sat = INTEG_W'(-qq[INTEG_W-1:0]);
         end
      end else begin
         if (qq > {{(PROD_W-INTEG_W+1){1'b0}}, {(INTEG_W-1){1'b1}}}) begin
            mul_sat = {1'b0, {(INTEG_W-1){1'b1}}};
         end else begin
            mul_sat = qq[INTEG_W-1:0];
         end
      end
   endfunction

   function automatic logic signed [INTEG_W-1:0] sat48(input logic signed [49:0] x);
      if (x > 50'sh0_7FFF_FFFF_FFFF) begin
         sat48 = {1'b0, {(INTEG_W-1){1'b1}}};
      end else if (x < -50'sh0_8000_0000_0000) begin
         sat48 = {1'b1, {(INTEG_W-1){1'b0}}};
      end else begin
         sat48 = x[INTEG_W-1:0];
      end
   endfunction

   // configuration
   logic [23:0] kp_ff, ki_ff;
   logic [15:0] dhi_ff, dlo_ff, wsp_ff;

   logic signed [INTEG_W-1:0] integ_r_ff, integ_l_ff;

   logic signed [15:0] vel_ff, omg_ff, ls_ff, rs_ff;
   logic [15:0]        dt_ff;

   state_type state_ff, state_in;
   step_type  step_ff, step_in;
   logic      wheel_ff, wheel_in;

   logic                      neg_ff;
   logic signed [32:0]        turn_ff;
   logic [DIVIDEND_W-1:0]     rate_ff;
   logic [39:0]               dtki_ff;
   logic [58:0]               dtrate_ff;
   logic signed [33:0]        e_ff;
   dir_type                   dir_ff;
   logic signed [INTEG_W-1:0] p_ff, t1_ff, t2_ff;
   logic signed [48:0]        v_ff;
   logic [23:0]               u_ff;
   logic signed [49:0]        diff_ff;
   dir_type                   dir_r_ff, dir_l_ff;
   logic [15:0]               drv_r_ff, drv_l_ff;

   logic        rsp_valid_ff;
   dir_type     rsp_ldir_ff, rsp_rdir_ff;
   logic [15:0] rsp_ldrv_ff, rsp_rdrv_ff;

   mdu_req_type       mdu_req;
   logic [OPA_W-1:0]  opa;
   logic [OPB_W-1:0]  opb;
   logic              neg_in;
   logic              mdu_done;
   logic [PROD_W-1:0] mdu_result;

   logic              req_take;
   logic              out_free;
   logic [15:0]       omg_mag;
   logic [33:0]       e_mag;
   logic [49:0]       diff_mag;
   logic [26:0]       ki5;

   ddw_mul_div u_mdu (
      .clock      (clock),
      .reset      (reset),
      .mdu_req    (mdu_req),
      .opa        (opa),
      .opb        (opb),
      .mdu_done   (mdu_done),
      .mdu_result (mdu_result)
   );

   assign req_stall = reset || (state_ff != ST_IDLE);
   assign req_take = req_valid && !req_stall;
   assign out_free = !rsp_valid_ff || !rsp_stall;

   // next state and sequence step
   always_comb begin
      state_in = state_ff;
      step_in = step_ff;
      wheel_in = wheel_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_take) begin
               state_in = ST_LAUNCH;
               step_in = OP_TURN;
               wheel_in = 1'b0;
            end
         end
         ST_LAUNCH: state_in = ST_WAIT;
         ST_WAIT: begin
            if (mdu_done) begin
               state_in = ST_POST;
            end
         end
         ST_POST: begin
            case (step_ff)
               OP_TURN: begin
                  state_in = ST_LAUNCH;
                  step_in = OP_RATE;
               end
               OP_RATE: begin
                  state_in = ST_LAUNCH;
                  step_in = OP_DTKI;
               end
               OP_DTKI: begin
                  state_in = ST_LAUNCH;
                  step_in = OP_DTRATE;
               end
               OP_DTRATE: begin
                  state_in = ST_ERR;
                  step_in = OP_PROP;
               end
               OP_PROP: begin
                  state_in = ST_MIX;
                  step_in = OP_T1;
               end
               OP_T1: begin
                  state_in = ST_LAUNCH;
                  step_in = OP_T2;
               end
               OP_T2: begin
                  state_in = ST_UPD;
                  step_in = OP_PROP;
               end
               default: state_in = ST_IDLE;
            endcase
         end
         ST_ERR: state_in = ST_LAUNCH;
         ST_MIX: state_in = ST_CLAMP;
         ST_CLAMP: state_in = ST_LAUNCH;
         ST_UPD: begin
            if (wheel_ff) begin
               state_in = ST_FIN;
            end else begin
               state_in = ST_ERR;
               wheel_in = 1'b1;
            end
         end
         ST_FIN: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // operands for the shared unit
   always_comb begin
      omg_mag = omg_ff[15] ? 16'(-omg_ff) : omg_ff;
      e_mag = e_ff[33] ? 34'(-e_ff) : e_ff;
      diff_mag = diff_ff[49] ? 50'(-diff_ff) : diff_ff;
      ki5 = {3'd0, ki_ff} + {1'b0, ki_ff, 2'd0};
      mdu_req.start = (state_ff == ST_LAUNCH);
      mdu_req.op = (step_ff == OP_RATE) ? MDU_DIV : MDU_MUL;
      opa = '0;
      opb = '0;
      neg_in = 1'b0;
      case (step_ff)
         OP_TURN: begin
            opa = {34'd0, omg_mag};
            opb = {44'd0, wsp_ff};
            neg_in = omg_ff[15];
         end
         OP_RATE: begin
            opa = {7'd0, ki5, 16'd0};
            opb = {36'd0, (kp_ff == '0) ? 24'd1 : kp_ff};
         end
         OP_DTKI: begin
            opa = {26'd0, ki_ff};
            opb = {44'd0, dt_ff};
         end
         OP_DTRATE: begin
            opa = {7'd0, rate_ff};
            opb = {44'd0, dt_ff};
         end
         OP_PROP: begin
            opa = {16'd0, e_mag};
            opb = {36'd0, kp_ff};
            neg_in = e_ff[33];
         end
         OP_T1: begin
            opa = {16'd0, e_mag};
            opb = {20'd0, dtki_ff};
            neg_in = e_ff[33];
         end
         OP_T2: begin
            opa = diff_mag;
            opb = {1'b0, dtrate_ff};
            neg_in = diff_ff[49];
         end
         default: begin
            opa = '0;
            opb = '0;
         end
      endcase
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         step_ff <= OP_TURN;
         wheel_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
         kp_ff <= PROP_GAIN_RST;
         ki_ff <= INTEG_GAIN_RST;
         dhi_ff <= DRIVE_HIGH_RST;
         dlo_ff <= DRIVE_LOW_RST;
         wsp_ff <= WHEEL_SPACING_RST;
         integ_r_ff <= '0;
         integ_l_ff <= '0;
      end else begin
         state_ff <= state_in;
         step_ff <= step_in;
         wheel_ff <= wheel_in;
         if (state_ff == ST_FIN && out_free) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
         if (csr_we) begin
            case (csr_index)
               CSR_PROP_GAIN: kp_ff <= csr_wdata;
               CSR_INTEG_GAIN: ki_ff <= csr_wdata;
               CSR_DRIVE_HIGH: dhi_ff <= csr_wdata[15:0];
               CSR_DRIVE_LOW: dlo_ff <= csr_wdata[15:0];
               CSR_WHEEL_SPACING: wsp_ff <= csr_wdata[15:0];
               default: ;
            endcase
         end
         if (state_ff == ST_UPD) begin
            if (wheel_ff) begin
               integ_l_ff <= sat48(50'(integ_l_ff) + 50'(t1_ff) + 50'(t2_ff));
            end else begin
               integ_r_ff <= sat48(50'(integ_r_ff) + 50'(t1_ff) + 50'(t2_ff));
            end
         end
      end
   end

   // datapath
   logic signed [33:0] tgt, meas;
   logic signed [34:0] e2;
   dir_type            dir_now;
   logic signed [48:0] lo_lim, hi_lim, u1, u2;

   always_comb begin
      if (wheel_ff) begin
         tgt = {{9{vel_ff[15]}}, vel_ff, 9'd0} - 34'(turn_ff);
         meas = {{9{ls_ff[15]}}, ls_ff, 9'd0};
      end else begin
         tgt = {{9{vel_ff[15]}}, vel_ff, 9'd0} + 34'(turn_ff);
         meas = {{9{rs_ff[15]}}, rs_ff, 9'd0};
      end
      if (tgt > 34'sd0) begin
         dir_now = DIR_FWD;
         e2 = 35'(tgt) - 35'(meas);
      end else if (tgt < 34'sd0) begin
         dir_now = DIR_BACK;
         e2 = 35'(meas) - 35'(tgt);
      end else begin
         dir_now = DIR_BRAKE;
         e2 = '0;
      end
      lo_lim = {25'd0, dlo_ff, 8'd0};
      hi_lim = {25'd0, dhi_ff, 8'd0};
      u1 = (v_ff < lo_lim) ? lo_lim : v_ff;
      u2 = (u1 > hi_lim) ? hi_lim : u1;
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         vel_ff <= req_linear_cmd;
         omg_ff <= req_angular_cmd;
         ls_ff <= req_left_speed;
         rs_ff <= req_right_speed;
         dt_ff <= req_step_time;
      end
      if (state_ff == ST_LAUNCH) begin
         neg_ff <= neg_in;
      end
      if (state_ff == ST_POST) begin
         case (step_ff)
            OP_TURN: turn_ff <= neg_ff ? -{1'b0, mdu_result[31:0]} : {1'b0, mdu_result[31:0]};
            OP_RATE: rate_ff <= mdu_result[DIVIDEND_W-1:0];
            OP_DTKI: dtki_ff <= mdu_result[39:0];
            OP_DTRATE: dtrate_ff <= mdu_result[58:0];
            OP_PROP: p_ff <= mul_sat(mdu_result, neg_ff, 6'd8);
            OP_T1: t1_ff <= mul_sat(mdu_result, neg_ff, 6'd24);
            OP_T2: t2_ff <= mul_sat(mdu_result, neg_ff, 6'd32);
            default: ;
         endcase
      end
      if (state_ff == ST_ERR) begin
         e_ff <= e2[34:1];
         dir_ff <= dir_now;
      end
      if (state_ff == ST_MIX) begin
         v_ff <= 49'(p_ff) + 49'(wheel_ff ? integ_l_ff : integ_r_ff);
      end
      if (state_ff == ST_CLAMP) begin
         u_ff <= u2[23:0];
         diff_ff <= 50'(u2) - 50'(v_ff);
      end
      if (state_ff == ST_UPD) begin
         if (wheel_ff) begin
            dir_l_ff <= dir_ff;
            drv_l_ff <= u_ff[23:8];
         end else begin
            dir_r_ff <= dir_ff;
            drv_r_ff <= u_ff[23:8];
         end
      end
      if (state_ff == ST_FIN && out_free) begin
         rsp_ldir_ff <= dir_l_ff;
         rsp_rdir_ff <= dir_r_ff;
         rsp_ldrv_ff <= drv_l_ff;
         rsp_rdrv_ff <= drv_r_ff;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_left_dir = rsp_ldir_ff;
   assign rsp_right_dir = rsp_rdir_ff;
   assign rsp_left_drive = rsp_ldrv_ff;
   assign rsp_right_drive = rsp_rdrv_ff;

endmodule

`default_nettype wire

// ===== rtl/ddw_checker.sv =====
// port-level checks for the differential-drive wheel pi controller
`default_nettype none

module ddw_checker import ddw_pkg::*; (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_stall,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic [1:0]  rsp_left_dir,
   input logic [1:0]  rsp_right_dir,
   input logic [15:0] rsp_left_drive,
   input logic [15:0] rsp_right_drive
);

   // a held response keeps its payload
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_left_drive)
         && $stable(rsp_right_drive) && $stable(rsp_left_dir) && $stable(rsp_right_dir))
      else $error("response changed while stalled");

   a_dir_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_left_dir <= DIR_BRAKE && rsp_right_dir <= DIR_BRAKE)
      else $error("invalid direction code");

   // one request in flight: busy right after a request is taken
   a_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("second request taken during a tick");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid after reset");

endmodule

bind diff_drive_wheel_pi_controller ddw_checker u_ddw_checker (.*);

`default_nettype wire

// ===== tb/sv/tb_diff_drive_wheel_pi_controller.sv =====
// testbench of the differential-drive wheel pi controller: directed table, then random ticks
`timescale 1ns / 100ps

module tb_diff_drive_wheel_pi_controller;
   import ddw_pkg::*;

   localparam longint I48_MAX = 64'sd140737488355327;
   localparam longint I48_MIN = -64'sd140737488355328;
   localparam int CYCLE_LIMIT = 4000000;
   localparam int PHASE_ITEMS = 240;
   localparam int SETTLE_CYCLES = 500;

   typedef struct packed {
      logic [15:0] linear_cmd;
      logic [15:0] angular_cmd;
      logic [15:0] left_speed;
      logic [15:0] right_speed;
      logic [15:0] step_time;
   } tick_type;

   typedef struct packed {
      logic [1:0]  left_dir;
      logic [1:0]  right_dir;
      logic [15:0] left_drive;
      logic [15:0] right_drive;
   } drive_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [15:0] req_linear_cmd = '0;
   logic [15:0] req_angular_cmd = '0;
   logic [15:0] req_left_speed = '0;
   logic [15:0] req_right_speed = '0;
   logic [15:0] req_step_time = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [1:0]  rsp_left_dir;
   logic [1:0]  rsp_right_dir;
   logic [15:0] rsp_left_drive;
   logic [15:0] rsp_right_drive;
   logic        csr_we = 1'b0;
   logic [2:0]  csr_index = CSR_PROP_GAIN;
   logic [23:0] csr_wdata = '0;

   // controller copy: registers and integrators
   logic [23:0] kp, ki;
   logic [15:0] lim_hi, lim_lo, spacing;
   longint      left_acc, right_acc;

   drive_type   expected_drives[$];
   int          mismatches = 0;
   int          sent = 0;
   int          cycles = 0;
   int          send_idle_pct = 13;
   int          recv_idle_pct = 62;
   bit          hold_done = 1'b0;
   int          hold_left = 0;

   diff_drive_wheel_pi_controller dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall),
      .req_linear_cmd(req_linear_cmd), .req_angular_cmd(req_angular_cmd),
      .req_left_speed(req_left_speed), .req_right_speed(req_right_speed),
      .req_step_time(req_step_time),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
      .rsp_left_dir(rsp_left_dir), .rsp_right_dir(rsp_right_dir),
      .rsp_left_drive(rsp_left_drive), .rsp_right_drive(rsp_right_drive),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   always #10 clock = ~clock;

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   // floor(x * m / 2^sh) saturated to the integrator range
   function automatic longint scaled_product(input longint x, input logic [63:0] m,
                                             input int sh);
      logic signed [127:0] prod;
      logic signed [127:0] hi_lim;
      logic signed [127:0] lo_lim;
      hi_lim = I48_MAX;
      lo_lim = I48_MIN;
      prod = $signed({{64{x[63]}}, x}) * $signed({64'd0, m});
      prod = prod >>> sh;
      if (prod > hi_lim) return I48_MAX;
      if (prod < lo_lim) return I48_MIN;
      return longint'(prod);
   endfunction

   function automatic longint sat_integ(input longint v);
      if (v > I48_MAX) return I48_MAX;
      if (v < I48_MIN) return I48_MIN;
      return v;
   endfunction

   // one pi step for one wheel, target and measurement in q.9
   function automatic logic [15:0] wheel_pi(input longint tgt, input longint meas,
                                            input logic [15:0] dt, inout longint acc,
                                            output logic [1:0] dir);
      logic [63:0] kdiv, rate;
      longint err2, err, p, v, u, t1, t2;
      kdiv = (kp == 0) ? 64'd1 : {40'd0, kp};
      rate = (({40'd0, ki} * 64'd5) << 16) / kdiv;
      if (tgt > 0) begin
         dir = DIR_FWD;
         err2 = tgt - meas;
      end else if (tgt < 0) begin
         dir = DIR_BACK;
         err2 = meas - tgt;
      end else begin
         dir = DIR_BRAKE;
         err2 = 0;
      end
      err = err2 >>> 1;
      p = scaled_product(err, {40'd0, kp}, 8);
      v = p + acc;
      u = v;
      if (u < longint'({lim_lo, 8'd0})) u = longint'({lim_lo, 8'd0});
      if (u > longint'({lim_hi, 8'd0})) u = longint'({lim_hi, 8'd0});
      t1 = scaled_product(err, {48'd0, dt} * {40'd0, ki}, 24);
      t2 = scaled_product(u - v, {48'd0, dt} * rate, 32);
      acc = sat_integ(acc + t1 + t2);
      return u[23:8];
   endfunction

   function automatic drive_type control_tick(input tick_type t);
      drive_type r;
      longint vel, turn;
      logic [1:0] d;
      vel = longint'($signed(t.linear_cmd));
      turn = longint'($signed(t.angular_cmd)) * longint'({48'd0, spacing});
      r.right_drive = wheel_pi(vel * 512 + turn, longint'($signed(t.right_speed)) * 512,
                               t.step_time, right_acc, d);
      r.right_dir = d;
      r.left_drive = wheel_pi(vel * 512 - turn, longint'($signed(t.left_speed)) * 512,
                              t.step_time, left_acc, d);
      r.left_dir = d;
      return r;
   endfunction

   // response side
   always @(posedge clock) begin
      drive_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_drives.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected response: dir %0d/%0d drive %0d/%0d",
                        rsp_left_dir, rsp_right_dir, rsp_left_drive, rsp_right_drive);
         end else begin
            want = expected_drives.pop_front();
            if (want !== {rsp_left_dir, rsp_right_dir, rsp_left_drive, rsp_right_drive}) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("mismatch: expected dir %0d/%0d drive %0d/%0d, got %0d/%0d %0d/%0d",
                           want.left_dir, want.right_dir, want.left_drive, want.right_drive,
                           rsp_left_dir, rsp_right_dir, rsp_left_drive, rsp_right_drive);
            end
         end
      end
   end

   // receiver stalls, with one long hold-off that fills the block
   always @(negedge clock) begin
      if (!hold_done && sent >= 300) begin
         hold_done <= 1'b1;
         hold_left <= 3000;
         rsp_stall <= 1'b1;
      end else if (hold_left > 0) begin
         hold_left <= hold_left - 1;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(99) < recv_idle_pct);
      end
   end

   task automatic send_tick(input tick_type t, input bit typed, input drive_type typed_drive);
      drive_type pred;
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_linear_cmd <= t.linear_cmd;
      req_angular_cmd <= t.angular_cmd;
      req_left_speed <= t.left_speed;
      req_right_speed <= t.right_speed;
      req_step_time <= t.step_time;
      do @(posedge clock); while (req_stall);
      pred = control_tick(t);
      expected_drives.push_back(typed ? typed_drive : pred);
      sent++;
      if (sent == 567) begin
         send_idle_pct = 62;
         recv_idle_pct = 13;
      end else if (sent == 1134) begin
         send_idle_pct = 0;
         recv_idle_pct = 0;
      end
      @(negedge clock);
   endtask

   task automatic write_csr(input logic [2:0] idx, input logic [23:0] val);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      case (idx)
         CSR_PROP_GAIN:     kp = val;
         CSR_INTEG_GAIN:    ki = val;
         CSR_DRIVE_HIGH:    lim_hi = val[15:0];
         CSR_DRIVE_LOW:     lim_lo = val[15:0];
         CSR_WHEEL_SPACING: spacing = val[15:0];
         default: ;
      endcase
      @(negedge clock);
      csr_we <= 1'b0;
   endtask

   task automatic load_settings(input logic [23:0] p, input logic [23:0] i,
                                input logic [15:0] hi, input logic [15:0] lo,
                                input logic [15:0] ws);
      req_valid <= 1'b0;
      wait (expected_drives.size() == 0);
      repeat (SETTLE_CYCLES) @(negedge clock);
      write_csr(CSR_PROP_GAIN, p);
      write_csr(CSR_INTEG_GAIN, i);
      write_csr(CSR_DRIVE_HIGH, {8'd0, hi});
      write_csr(CSR_DRIVE_LOW, {8'd0, lo});
      write_csr(CSR_WHEEL_SPACING, {8'd0, ws});
   endtask

   function automatic logic [15:0] rand_field();
      case ($urandom_range(9))
         0, 1:    return $urandom_range(3) == 0 ? 16'h8000 :
                         ($urandom_range(2) == 0 ? 16'h7fff :
                         ($urandom_range(1) ? 16'h0000 : 16'hffff));
         2, 3, 4: return 16'($urandom());
         default: return 16'($signed($urandom_range(4000)) - 2000);
      endcase
   endfunction

   function automatic tick_type rand_tick();
      tick_type t;
      t.linear_cmd = rand_field();
      t.angular_cmd = ($urandom_range(4) == 0) ? 16'h0000 : rand_field();
      t.left_speed = rand_field();
      t.right_speed = rand_field();
      t.step_time = ($urandom_range(3) == 0) ? 16'($urandom()) : 16'($urandom_range(1500));
      return t;
   endfunction

   initial begin
      tick_type  rows[$];
      bit        row_typed[$];
      drive_type row_drive[$];
      int        k, ph;
      kp = PROP_GAIN_RST;
      ki = INTEG_GAIN_RST;
      lim_hi = DRIVE_HIGH_RST;
      lim_lo = DRIVE_LOW_RST;
      spacing = WHEEL_SPACING_RST;
      left_acc = 0;
      right_acc = 0;

      // zero command with no time step: both wheels brake at the low limit
      rows.push_back({16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000});
      row_typed.push_back(1);
      row_drive.push_back({DIR_BRAKE, DIR_BRAKE, DRIVE_LOW_RST, DRIVE_LOW_RST});
      // full forward against full reverse speed saturates at the high limit
      rows.push_back({16'h7fff, 16'h0000, 16'h8000, 16'h8000, 16'h0000});
      row_typed.push_back(1);
      row_drive.push_back({DIR_FWD, DIR_FWD, DRIVE_HIGH_RST, DRIVE_HIGH_RST});
      rows.push_back({16'h8000, 16'h0000, 16'h7fff, 16'h7fff, 16'h0000});
      row_typed.push_back(1);
      row_drive.push_back({DIR_BACK, DIR_BACK, DRIVE_HIGH_RST, DRIVE_HIGH_RST});
      rows.push_back({16'h7fff, 16'h7fff, 16'h8000, 16'h7fff, 16'hffff});
      rows.push_back({16'h8000, 16'h8000, 16'h7fff, 16'h8000, 16'hffff});
      rows.push_back({16'h0000, 16'h7fff, 16'h0100, 16'hff00, 16'h0100});
      rows.push_back({16'h0000, 16'h8000, 16'hffff, 16'h0001, 16'h0100});
      rows.push_back({16'h0000, 16'h0000, 16'h7fff, 16'h8000, 16'hffff});
      rows.push_back({16'h0100, 16'h0000, 16'h0100, 16'h0100, 16'h0148});
      rows.push_back({16'h0100, 16'h0080, 16'h0000, 16'h0000, 16'h0148});
      rows.push_back({16'hff00, 16'h0040, 16'hff80, 16'hff00, 16'h0148});
      rows.push_back({16'h0001, 16'hffff, 16'h0000, 16'h0000, 16'h0001});
      rows.push_back({16'hffff, 16'h0001, 16'hffff, 16'hffff, 16'h8000});
      rows.push_back({16'h5555, 16'haaaa, 16'h5555, 16'haaaa, 16'h5555});
      rows.push_back({16'haaaa, 16'h5555, 16'haaaa, 16'h5555, 16'haaaa});
      while (row_typed.size() < rows.size()) begin
         row_typed.push_back(0);
         row_drive.push_back('0);
      end

      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      for (k = 0; k < rows.size(); k++)
         send_tick(rows[k], row_typed[k], row_drive[k]);

      for (ph = 0; ph < 7; ph++) begin
         case (ph)
            0: ;
            1: load_settings(24'd1, 24'd1, 16'hffff, 16'h0000, 16'h0000);
            2: load_settings(24'hffffff, 24'hffffff, 16'hffff, 16'hffff, 16'hffff);
            3: load_settings(24'd0, 24'd0, DRIVE_HIGH_RST, DRIVE_LOW_RST, 16'd38);
            // low limit above high limit
            4: load_settings(24'd51200, 24'd12800, 16'd11520, 16'd25600, 16'd300);
            5: load_settings(24'($urandom()), 24'($urandom()), 16'($urandom()),
                             16'($urandom()), 16'($urandom()));
            default: load_settings(24'($urandom_range(100000, 1)),
                                   24'($urandom_range(50000, 1)), 16'd25600, 16'd2560,
                                   16'($urandom_range(600)));
         endcase
         for (k = 0; k < PHASE_ITEMS; k++)
            send_tick(rand_tick(), 0, '0);
      end

      req_valid <= 1'b0;
      wait (expected_drives.size() == 0);
      repeat (SETTLE_CYCLES) @(negedge clock);
      if (mismatches == 0 && expected_drives.size() == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule
